@@ rtl/cqs_pkg.sv @@
// shared types and constants for the circular queue with search
`default_nettype none

package cqs_pkg;

	// default queue depth and fixed field widths
	localparam int DEPTH_DEF = 128;
	localparam int DATA_W    = 32;
	localparam int FIELD_W   = 8;

	// request codes
	typedef enum logic [1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_SRCH = 2'd2,
		REQ_NOP  = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ,
		S_SCAN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    enq_write;
		logic    rd_head;
		logic    scan_next;
		logic    deq_pop;
		logic    out_load;
		status_t out_status;
		logic    data_sel;
		logic    pos_sel;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic hit;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/cqs_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none

module cqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/cqs_ctrl.sv @@
// controller state machine for the circular queue with search
`default_nettype none

module cqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cqs_pkg::dp_stat_t stat,
	output cqs_pkg::dp_cmd_t  cmd
);
	import cqs_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new result
	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.out_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.req)
					REQ_ENQ: begin
						if (out_free) begin
							cmd.enq_write  = !stat.full;
							cmd.out_load   = 1'b1;
							cmd.out_status = stat.full ? ST_FULL : ST_OK;
							state_d        = S_IDLE;
						end
					end
					REQ_DEQ: begin
						if (!stat.empty) begin
							cmd.rd_head = 1'b1;
							state_d     = S_DEQ;
						end else if (out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_status = ST_EMPTY;
							state_d        = S_IDLE;
						end
					end
					REQ_SRCH: begin
						if (!stat.empty) begin
							cmd.rd_head = 1'b1;
							state_d     = S_SCAN;
						end else if (out_free) begin
							cmd.out_load   = 1'b1;
							cmd.out_status = ST_NOTFOUND;
							state_d        = S_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							cmd.out_load = 1'b1;
							state_d      = S_IDLE;
						end
					end
				endcase
			end
			S_DEQ: begin
				if (out_free) begin
					cmd.deq_pop  = 1'b1;
					cmd.out_load = 1'b1;
					cmd.data_sel = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				priority if (stat.hit) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						cmd.pos_sel  = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (stat.last) begin
					if (out_free) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = ST_NOTFOUND;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/cqs_dp.sv @@
// datapath: pointers, count, entry ram, scan and result registers
`default_nettype none

module cqs_dp #(
	parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          req_type,
	input  logic signed [cqs_pkg::DATA_W-1:0]   data_in,
	input  cqs_pkg::dp_cmd_t                    cmd,
	output cqs_pkg::dp_stat_t                   stat,
	output cqs_pkg::status_t                    status,
	output logic signed [cqs_pkg::DATA_W-1:0]   data_out,
	output logic [cqs_pkg::FIELD_W-1:0]         position,
	output logic [cqs_pkg::FIELD_W-1:0]         occupancy,
	output logic [cqs_pkg::FIELD_W-1:0]         free_slots
);
	import cqs_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int EXT_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

	req_t              req_q;
	logic [DATA_W-1:0] word_q;
	logic [ADDR_W-1:0] head_q, tail_q, addr_q, k_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  k_plus1;
	logic [EXT_W-1:0]  pos_ext, occ_ext, free_ext;
	logic [DATA_W-1:0] rd_data;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;

	status_t           status_q;
	logic [DATA_W-1:0] data_q;
	logic [FIELD_W-1:0] pos_q, occ_q, free_q;

	function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + ADDR_W'(1);
	endfunction

	// latched request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_t'(req_type);
			word_q <= data_in;
		end
	end

	// count after this cycle's operation
	always_comb begin
		priority if (cmd.enq_write) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.deq_pop) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	// head, tail and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.enq_write) begin
				tail_q <= next_slot(tail_q);
			end
			if (cmd.deq_pop) begin
				head_q <= next_slot(head_q);
			end
		end
	end

	// scan read pointer and entry offset
	always_ff @(posedge clk) begin
		if (cmd.rd_head) begin
			addr_q <= next_slot(head_q);
			k_q    <= '0;
		end else if (cmd.scan_next) begin
			addr_q <= next_slot(addr_q);
			k_q    <= k_q + ADDR_W'(1);
		end
	end

	// entry store
	assign rd_en   = cmd.rd_head || cmd.scan_next;
	assign rd_addr = cmd.rd_head ? head_q : addr_q;

	cqs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.enq_write),
		.wr_addr (tail_q),
		.wr_data (word_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status toward the controller
	assign k_plus1    = CNT_W'(k_q) + CNT_W'(1);
	assign stat.req   = req_q;
	assign stat.full  = (count_q == DEPTH_CNT);
	assign stat.empty = (count_q == '0);
	assign stat.hit   = (rd_data == word_q);
	assign stat.last  = (k_plus1 == count_q);

	// result fields masked to eight bits
	assign pos_ext  = EXT_W'(k_plus1);
	assign occ_ext  = EXT_W'(count_d);
	assign free_ext = EXT_W'(DEPTH_CNT - count_d);

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			data_q   <= cmd.data_sel ? rd_data : '0;
			pos_q    <= cmd.pos_sel ? pos_ext[FIELD_W-1:0] : '0;
			occ_q    <= occ_ext[FIELD_W-1:0];
			free_q   <= free_ext[FIELD_W-1:0];
		end
	end

	assign status     = status_q;
	assign data_out   = data_q;
	assign position   = pos_q;
	assign occupancy  = occ_q;
	assign free_slots = free_q;

endmodule

`default_nettype wire

@@ rtl/circular_queue_with_search_core.sv @@
// top level of the circular queue with search
`default_nettype none

// Fixed-depth FIFO of signed 32-bit words held in a single-port-read RAM.
// Each request enqueues, dequeues, searches or does nothing, and each gives
// one result with a status, the dequeued word, the 1-based search position,
// and the occupancy and free space after the request. Requests are taken
// one at a time. An enqueue loads its result from the execute state, a
// dequeue after one RAM read of the head entry, and a search after it has
// read entries from the head on until a match or the last entry; the scan
// reads one entry per cycle through the RAM read port. A result waits to
// be loaded while the output register holds a stalled result. The next
// request is accepted the cycle after a result is loaded, while that result
// may still wait in the output register. The RAM needs no initialization:
// only occupied slots are read.
module circular_queue_with_search_core #(
	parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic signed [cqs_pkg::DATA_W-1:0] data_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [cqs_pkg::DATA_W-1:0] data_out,
	output logic [cqs_pkg::FIELD_W-1:0]       position,
	output logic [cqs_pkg::FIELD_W-1:0]       occupancy,
	output logic [cqs_pkg::FIELD_W-1:0]       free_slots
);
	import cqs_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	status_t status_w;

	// control
	cqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	cqs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.data_in    (data_in),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status_w),
		.data_out   (data_out),
		.position   (position),
		.occupancy  (occupancy),
		.free_slots (free_slots)
	);

	assign status = status_w;

	// an accepted request blocks the input until its result is loaded
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after request accepted");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a stalled result");

	// no write into a full queue
	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_write |-> !stat.full)
		else $error("enqueue write while full");

	// occupancy and free space always add up to the depth
	a_occ_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (FIELD_W'(occupancy + free_slots) == FIELD_W'(DEPTH)))
		else $error("occupancy and free space disagree");

endmodule

`default_nettype wire
